FILE: design/mmcs_pkg.sv
// ============================================================================
// mmcs_pkg - shared definitions for the min/max contrast stretch unit
// Codes, defaults and the queue status bundle used across the design.
// ============================================================================
package mmcs_pkg;

    // default sample width and command queue depth
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH_DEF  = 2;

    // display level
    localparam int         LEVEL_W   = 8;
    localparam logic [7:0] LEVEL_MAX = 8'hFF;
    localparam logic [7:0] LEVEL_MIN = 8'h00;

    // reset value of the fixed white level, truncated to the sample width
    localparam int FIXED_MAX_RESET = 32767;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIXED_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIXED_MIN    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIXED_MAX    = 2'd2;

    // request and result kinds
    localparam logic REQ_MEASURE = 1'b0;
    localparam logic REQ_MAP     = 1'b1;
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_MAP    = 1'b1;

    // command queue status toward front and back
    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

endpackage

FILE: design/mmcs_queue.sv
// ============================================================================
// mmcs_queue - short command queue
// Register based FIFO between front and back; push and pop may coincide.
// ============================================================================
module mmcs_queue #(
    parameter int WIDTH = 49,
    parameter int DEPTH = mmcs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [WIDTH-1:0]      wr_data,
    input  logic                  rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output mmcs_pkg::queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_en && !status.empty;
    assign rd_data      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: design/mmcs_front.sv
// ============================================================================
// mmcs_front - intake and classification
// Holds configuration, tracks the running range, issues queue commands.
// ============================================================================
module mmcs_front #(
    parameter int SAMPLE_WIDTH = mmcs_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [mmcs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [SAMPLE_WIDTH-1:0]             cfg_data,
    input  logic                                accept,
    input  logic                                req_type,
    input  logic signed [SAMPLE_WIDTH-1:0]      sample,
    input  logic                                last,
    output logic                                cmd_push,
    output logic [3*SAMPLE_WIDTH:0]             cmd_data
);

    localparam logic [SAMPLE_WIDTH-1:0] FIXED_MAX_RST =
        SAMPLE_WIDTH'(mmcs_pkg::FIXED_MAX_RESET);

    logic                            fixed_en_reg;
    logic signed [SAMPLE_WIDTH-1:0]  fixed_min_reg, fixed_max_reg;
    logic signed [SAMPLE_WIDTH-1:0]  run_min_reg, run_max_reg;
    logic signed [SAMPLE_WIDTH-1:0]  held_min_reg, held_max_reg;
    logic                            pass_empty_reg;
    logic signed [SAMPLE_WIDTH-1:0]  run_min_next, run_max_next;
    logic signed [SAMPLE_WIDTH-1:0]  lo, hi;
    logic                            is_map;

    assign is_map = (req_type == mmcs_pkg::REQ_MAP);

    // running range including this sample
    always_comb
    begin
        if (pass_empty_reg)
        begin
            run_min_next = sample;
            run_max_next = sample;
        end
        else
        begin
            run_min_next = (sample < run_min_reg) ? sample : run_min_reg;
            run_max_next = (sample > run_max_reg) ? sample : run_max_reg;
        end
    end

    always_comb
    begin
        if (is_map)
        begin
            lo = fixed_en_reg ? fixed_min_reg : held_min_reg;
            hi = fixed_en_reg ? fixed_max_reg : held_max_reg;
        end
        else
        begin
            lo = run_min_next;
            hi = run_max_next;
        end
    end

    assign cmd_push = accept && (is_map || last);
    assign cmd_data = {is_map ? mmcs_pkg::KIND_MAP : mmcs_pkg::KIND_REPORT, sample, lo, hi};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fixed_en_reg   <= 1'b0;
            fixed_min_reg  <= '0;
            fixed_max_reg  <= FIXED_MAX_RST;
            run_min_reg    <= '0;
            run_max_reg    <= '0;
            held_min_reg   <= '0;
            held_max_reg   <= '0;
            pass_empty_reg <= 1'b1;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    mmcs_pkg::CFG_FIXED_ENABLE: fixed_en_reg  <= cfg_data[0];
                    mmcs_pkg::CFG_FIXED_MIN:    fixed_min_reg <= cfg_data;
                    mmcs_pkg::CFG_FIXED_MAX:    fixed_max_reg <= cfg_data;
                    default:                    ;
                endcase
            end
            if (accept && !is_map)
            begin
                run_min_reg <= run_min_next;
                run_max_reg <= run_max_next;
                if (last)
                begin
                    held_min_reg   <= run_min_next;
                    held_max_reg   <= run_max_next;
                    pass_empty_reg <= 1'b1;
                end
                else
                begin
                    pass_empty_reg <= 1'b0;
                end
            end
        end
    end

endmodule

FILE: design/mmcs_back.sv
// ============================================================================
// mmcs_back - level mapping and result register
// Pops commands, scales through a radix-2 divider, holds one result.
// ============================================================================
module mmcs_back #(
    parameter int SAMPLE_WIDTH = mmcs_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mmcs_pkg::queue_status_t             q_status,
    input  logic [3*SAMPLE_WIDTH:0]             cmd_data,
    output logic                                cmd_pop,
    input  logic                                pop,
    output logic                                empty,
    output logic                                kind,
    output logic [mmcs_pkg::LEVEL_W-1:0]        level,
    output logic signed [SAMPLE_WIDTH-1:0]      range_min,
    output logic signed [SAMPLE_WIDTH-1:0]      range_max,
    output logic                                flat
);

    localparam int LW    = mmcs_pkg::LEVEL_W;
    localparam int DIF_W = SAMPLE_WIDTH + 1;
    localparam int NUM_W = DIF_W + LW;
    localparam int DSH_W = DIF_W + LW - 1;
    localparam int CNT_W = $clog2(LW);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DIV  = 2'b10
    } back_state_t;

    back_state_t                    state_reg, state_next;
    logic                           out_valid_reg;
    logic                           out_kind_reg, out_flat_reg;
    logic [LW-1:0]                  out_level_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_min_reg, out_max_reg;
    logic [NUM_W-1:0]               rem_reg;
    logic [DSH_W-1:0]               dsh_reg;
    logic [LW-1:0]                  quo_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic signed [SAMPLE_WIDTH-1:0] div_lo_reg, div_hi_reg;

    logic                           c_kind;
    logic signed [SAMPLE_WIDTH-1:0] c_sample, c_lo, c_hi;
    logic                           c_flat, c_below, c_above, c_direct;
    logic [DIF_W-1:0]               dif_num, dif_den;
    logic                           out_free, take, fits, finish, div_step;
    logic [LW-1:0]                  quo_new;
    logic [LW-1:0]                  direct_level;

    assign {c_kind, c_sample, c_lo, c_hi} = cmd_data;
    assign c_flat  = (c_hi <= c_lo);
    assign c_below = (c_sample <= c_lo);
    assign c_above = (c_sample >= c_hi);
    // report, flat range or saturated sample: no division
    assign c_direct = (c_kind == mmcs_pkg::KIND_REPORT) || c_flat || c_below || c_above;
    assign direct_level = ((c_kind == mmcs_pkg::KIND_MAP) && !c_flat && c_above)
                          ? mmcs_pkg::LEVEL_MAX : mmcs_pkg::LEVEL_MIN;

    assign dif_num = {c_sample[SAMPLE_WIDTH-1], c_sample} - {c_lo[SAMPLE_WIDTH-1], c_lo};
    assign dif_den = {c_hi[SAMPLE_WIDTH-1], c_hi} - {c_lo[SAMPLE_WIDTH-1], c_lo};

    assign out_free = !out_valid_reg || pop;
    assign take     = (state_reg == ST_IDLE) && !q_status.empty && out_free;
    assign cmd_pop  = take;

    // one quotient bit per cycle; the last bit waits until the result register is free
    assign fits     = (rem_reg >= {1'b0, dsh_reg});
    assign quo_new  = {quo_reg[LW-2:0], fits};
    assign finish   = (state_reg == ST_DIV) && (cnt_reg == '0) && out_free;
    assign div_step = (state_reg == ST_DIV) && ((cnt_reg != '0) || out_free);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take && !c_direct)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((take && c_direct) || finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && c_direct)
        begin
            out_kind_reg  <= c_kind;
            out_level_reg <= direct_level;
            out_min_reg   <= c_lo;
            out_max_reg   <= c_hi;
            out_flat_reg  <= c_flat;
        end
        else if (finish)
        begin
            out_kind_reg  <= mmcs_pkg::KIND_MAP;
            out_level_reg <= quo_new;
            out_min_reg   <= div_lo_reg;
            out_max_reg   <= div_hi_reg;
            out_flat_reg  <= 1'b0;
        end

        if (take && !c_direct)
        begin
            // numerator (s - lo) * 255, divisor (hi - lo) aligned to the top bit
            rem_reg    <= {dif_num, {LW{1'b0}}} - {{LW{1'b0}}, dif_num};
            dsh_reg    <= {dif_den, {(LW-1){1'b0}}};
            quo_reg    <= '0;
            cnt_reg    <= CNT_W'(LW - 1);
            div_lo_reg <= c_lo;
            div_hi_reg <= c_hi;
        end
        else if (div_step)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - {1'b0, dsh_reg};
            end
            dsh_reg <= dsh_reg >> 1;
            quo_reg <= quo_new;
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign empty     = !out_valid_reg;
    assign kind      = out_kind_reg;
    assign level     = out_level_reg;
    assign range_min = out_min_reg;
    assign range_max = out_max_reg;
    assign flat      = out_flat_reg;

endmodule

FILE: design/min_max_contrast_stretch_unit.sv
// ============================================================================
// min_max_contrast_stretch_unit - linear min/max contrast stretch
// Measures the range of signed samples and maps samples to 8-bit grey levels.
// ============================================================================
//
//  channel   dir   handshake               payload
//  -------   ---   ---------------------   ------------------------------------
//  input     in    push / full             req_type, sample, last
//  result    out   empty / pop             kind, level, range_min, range_max, flat
//  config    in    cfg_write               cfg_index, cfg_data
//
//  Measure items are taken one per cycle while full is low; the running range
//  is updated in the front in the cycle of the transfer. A report or a flat or
//  saturated map item needs no division; other map items run the restoring
//  divider in the back, one quotient bit per cycle, the last bit waiting for a
//  free result register. Reset is asynchronous and clears all control state
//  and the range registers. A two-entry command queue lets the front keep
//  taking items while the back divides or the result register waits for pop.
//
module min_max_contrast_stretch_unit #(
    parameter int SAMPLE_WIDTH = mmcs_pkg::SAMPLE_WIDTH_DEF,
    parameter int QUEUE_DEPTH  = mmcs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_write,
    input  logic [mmcs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [SAMPLE_WIDTH-1:0]             cfg_data,
    // input queue side
    input  logic                                push,
    output logic                                full,
    input  logic                                req_type,
    input  logic signed [SAMPLE_WIDTH-1:0]      sample,
    input  logic                                last,
    // result queue side
    output logic                                empty,
    input  logic                                pop,
    output logic                                kind,
    output logic [mmcs_pkg::LEVEL_W-1:0]        level,
    output logic signed [SAMPLE_WIDTH-1:0]      range_min,
    output logic signed [SAMPLE_WIDTH-1:0]      range_max,
    output logic                                flat
);

    // command = {kind, sample, lo, hi}
    localparam int CMD_W = 3 * SAMPLE_WIDTH + 1;

    mmcs_pkg::queue_status_t q_status;
    logic                    accept;
    logic                    q_push, q_pop;
    logic [CMD_W-1:0]        q_wr_data, q_rd_data;

    assign full   = q_status.full;
    assign accept = push && !q_status.full;

    // front: config registers, running/held range, command issue
    mmcs_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .req_type  (req_type),
        .sample    (sample),
        .last      (last),
        .cmd_push  (q_push),
        .cmd_data  (q_wr_data)
    );

    mmcs_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .status  (q_status)
    );

    // back: level scaling and the result register
    mmcs_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .cmd_data  (q_rd_data),
        .cmd_pop   (q_pop),
        .pop       (pop),
        .empty     (empty),
        .kind      (kind),
        .level     (level),
        .range_min (range_min),
        .range_max (range_max),
        .flat      (flat)
    );

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.empty && q_status.full))
        else $error("command queue reports empty and full together");

    a_measure_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_type == mmcs_pkg::REQ_MEASURE) && !last) |-> !q_push)
        else $error("measure transfer without last issued a command");

    a_map_issues: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_type == mmcs_pkg::REQ_MAP)) |-> q_push)
        else $error("map transfer issued no command");

    a_report_level: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (kind == mmcs_pkg::KIND_REPORT)) |-> (level == mmcs_pkg::LEVEL_MIN))
        else $error("range report carries a nonzero level");

    a_flat_level: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (kind == mmcs_pkg::KIND_MAP) && flat) |-> (level == mmcs_pkg::LEVEL_MIN))
        else $error("flat map result carries a nonzero level");

endmodule

FILE: bench/mmcs_stretch_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// mmcs_stretch_checker - scoreboard for the min/max contrast stretch unit
// Mirrors the configuration writes, predicts the range reports and grey levels
// of every accepted item, and compares each result transfer in order.
// ============================================================================
module mmcs_stretch_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [mmcs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [15:0]                         cfg_data,
    input  logic                                push,
    input  logic                                full,
    input  logic                                req_type,
    input  logic signed [15:0]                  sample,
    input  logic                                last,
    input  logic                                empty,
    input  logic                                pop,
    input  logic                                kind,
    input  logic [mmcs_pkg::LEVEL_W-1:0]        level,
    input  logic signed [15:0]                  range_min,
    input  logic signed [15:0]                  range_max,
    input  logic                                flat,
    output int                                  error_count,
    output int                                  outstanding
);

    typedef struct packed {
        logic                         kind;
        logic [mmcs_pkg::LEVEL_W-1:0] level;
        logic signed [15:0]           lo;
        logic signed [15:0]           hi;
        logic                         flat;
    } stretch_out_t;

    stretch_out_t       due_stretch_q[$];

    // register mirror
    logic               fixed_on;
    logic signed [15:0] fixed_lo;
    logic signed [15:0] fixed_hi;

    // range tracking
    logic signed [15:0] run_lo;
    logic signed [15:0] run_hi;
    logic               pass_fresh;
    logic signed [15:0] held_lo;
    logic signed [15:0] held_hi;

    // returns 1 when the item produces a result
    function automatic bit predict_stretch(input logic rt, input logic signed [15:0] s,
                                           input logic lst, output stretch_out_t res);
        int lo;
        int hi;
        res = '0;
        if (rt == mmcs_pkg::REQ_MEASURE)
        begin
            if (pass_fresh)
            begin
                run_lo     = s;
                run_hi     = s;
                pass_fresh = 1'b0;
            end
            else
            begin
                if (s < run_lo) run_lo = s;
                if (s > run_hi) run_hi = s;
            end
            if (!lst)
                return 1'b0;
            held_lo    = run_lo;
            held_hi    = run_hi;
            pass_fresh = 1'b1;
            res.kind   = mmcs_pkg::KIND_REPORT;
            res.level  = mmcs_pkg::LEVEL_MIN;
            res.lo     = held_lo;
            res.hi     = held_hi;
            res.flat   = (held_hi <= held_lo);
            return 1'b1;
        end
        lo       = fixed_on ? int'(fixed_lo) : int'(held_lo);
        hi       = fixed_on ? int'(fixed_hi) : int'(held_hi);
        res.kind = mmcs_pkg::KIND_MAP;
        res.lo   = lo[15:0];
        res.hi   = hi[15:0];
        if (hi <= lo)
        begin
            res.flat  = 1'b1;
            res.level = mmcs_pkg::LEVEL_MIN;
        end
        else if (int'(s) <= lo)
            res.level = mmcs_pkg::LEVEL_MIN;
        else if (int'(s) >= hi)
            res.level = mmcs_pkg::LEVEL_MAX;
        else
            res.level = 8'(((int'(s) - lo) * 255) / (hi - lo));
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        stretch_out_t got;
        stretch_out_t want;
        if (!rst_n)
        begin
            fixed_on    = 1'b0;
            fixed_lo    = '0;
            fixed_hi    = 16'(mmcs_pkg::FIXED_MAX_RESET);
            run_lo      = '0;
            run_hi      = '0;
            pass_fresh  = 1'b1;
            held_lo     = '0;
            held_hi     = '0;
            due_stretch_q.delete();
            error_count = 0;
            outstanding = 0;
        end
        else
        begin
            // result side first: a result can never belong to this edge's input
            if (pop && !empty)
            begin
                got = {kind, level, range_min, range_max, flat};
                if (due_stretch_q.size() == 0)
                begin
                    $display("%0t: unexpected result kind=%0d level=%0d min=%0d max=%0d flat=%0d",
                             $time, kind, level, range_min, range_max, flat);
                    error_count++;
                end
                else
                begin
                    want = due_stretch_q.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: mismatch expected kind=%0d level=%0d min=%0d max=%0d flat=%0d",
                                 $time, want.kind, want.level, want.lo, want.hi, want.flat);
                        $display("%0t:          actual   kind=%0d level=%0d min=%0d max=%0d flat=%0d",
                                 $time, kind, level, range_min, range_max, flat);
                        error_count++;
                    end
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    mmcs_pkg::CFG_FIXED_ENABLE: fixed_on = cfg_data[0];
                    mmcs_pkg::CFG_FIXED_MIN:    fixed_lo = cfg_data;
                    mmcs_pkg::CFG_FIXED_MAX:    fixed_hi = cfg_data;
                    default:                    ;
                endcase
            end
            if (push && !full)
            begin
                if (predict_stretch(req_type, sample, last, want))
                    due_stretch_q.push_back(want);
            end
            outstanding = due_stretch_q.size();
        end
    end

endmodule

FILE: bench/min_max_contrast_stretch_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// min_max_contrast_stretch_unit_tb - testbench for the contrast stretch unit
// Directed corner items, then phases of random measure passes and map bursts
// under varied idling and register settings; a checker compares every result.
// ============================================================================
module min_max_contrast_stretch_unit_tb;

    // register index outside the list; writes to it must be ignored
    localparam logic [mmcs_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               cfg_write;
    logic [mmcs_pkg::CFG_INDEX_W-1:0]   cfg_index;
    logic [15:0]                        cfg_data;
    logic                               push;
    logic                               full;
    logic                               req_type;
    logic signed [15:0]                 sample;
    logic                               last;
    logic                               empty;
    logic                               pop = 1'b0;
    logic                               kind;
    logic [mmcs_pkg::LEVEL_W-1:0]       level;
    logic signed [15:0]                 range_min;
    logic signed [15:0]                 range_max;
    logic                               flat;

    int                     error_count;
    int                     outstanding;

    // idling knobs, percent of cycles
    int                     send_idle_pct  = 0;
    int                     recv_stall_pct = 0;

    // long receiver hold-off, requested by the stimulus
    logic                   hold_phase = 1'b0;
    logic                   rx_block   = 1'b0;

    int                     items_sent = 0;

    // testbench copy of the fixed range, used to aim map samples
    logic                   fixed_on;
    logic signed [15:0]     fixed_lo;
    logic signed [15:0]     fixed_hi;

    always #1 clk = ~clk;

    min_max_contrast_stretch_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .req_type  (req_type),
        .sample    (sample),
        .last      (last),
        .empty     (empty),
        .pop       (pop),
        .kind      (kind),
        .level     (level),
        .range_min (range_min),
        .range_max (range_max),
        .flat      (flat)
    );

    mmcs_stretch_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .req_type    (req_type),
        .sample      (sample),
        .last        (last),
        .empty       (empty),
        .pop         (pop),
        .kind        (kind),
        .level       (level),
        .range_min   (range_min),
        .range_max   (range_max),
        .flat        (flat),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    // ------------------------------------------------------------------------
    // Result side: pop at random per recv_stall_pct, forced low while the
    // long hold-off runs.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= !rx_block && ($urandom_range(99) >= recv_stall_pct);
    end

    // Long hold-off, counted here so the sender keeps pushing meanwhile and
    // the unit backs up all the way to full.
    initial
    begin
        wait (hold_phase);
        @(posedge clk);
        rx_block <= 1'b1;
        repeat (400) @(posedge clk);
        rx_block <= 1'b0;
    end

    // Run limit; far above the slowest legal run.
    initial
    begin
        #600000;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Clamped random sample in base .. base+span.
    function automatic logic signed [15:0] pick_sample(input int base, input int span);
        int v;
        v = base + int'($urandom_range(span));
        if (v < -32768) v = -32768;
        if (v > 32767)  v = 32767;
        return v[15:0];
    endfunction

    // One input transfer. push is left high on return so back-to-back items
    // need no second assignment in the same step; idle cycles drop it.
    task automatic send_item(input logic rt, input logic signed [15:0] s, input logic lst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push     <= 1'b1;
        req_type <= rt;
        sample   <= s;
        last     <= lst;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
    endtask

    // Wait for every due result plus the divider's worst latency, so the unit
    // is idle before a register write.
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_reg(input logic [mmcs_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [15:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Writes all registers, plus a throwaway write to the unused index.
    task automatic set_config(input logic en, input logic signed [15:0] lo,
                              input logic signed [15:0] hi);
        write_reg(mmcs_pkg::CFG_FIXED_ENABLE, {15'b0, en});
        write_reg(mmcs_pkg::CFG_FIXED_MIN, lo);
        write_reg(mmcs_pkg::CFG_FIXED_MAX, hi);
        write_reg(CFG_UNUSED, 16'($urandom));
        cfg_write <= 1'b0;
        fixed_on  = en;
        fixed_lo  = lo;
        fixed_hi  = hi;
    endtask

    // Sample window of a pass: full scale, narrow, constant or medium.
    task automatic pick_window(output int base, output int span);
        case ($urandom_range(3))
            0:
            begin
                base = -32768;
                span = 65535;
            end
            1:
            begin
                base = int'($urandom_range(65535)) - 32768;
                span = $urandom_range(1, 255);
            end
            2:
            begin
                base = int'($urandom_range(65535)) - 32768;
                span = 0;
            end
            default:
            begin
                base = int'($urandom_range(65535)) - 32768;
                span = $urandom_range(256, 8000);
            end
        endcase
    endtask

    task automatic measure_pass(input int base, input int span, input int len);
        for (int i = 0; i < len; i++)
            send_item(mmcs_pkg::REQ_MEASURE, pick_sample(base, span), i == len - 1);
    endtask

    // Map items mostly in and just around the window, some anywhere;
    // last is random since the unit ignores it on map items.
    task automatic map_burst(input int base, input int span, input int len);
        int ext;
        ext = span / 8 + 2;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(9) < 7)
                send_item(mmcs_pkg::REQ_MAP, pick_sample(base - ext, span + 2 * ext),
                          1'($urandom_range(1)));
            else
                send_item(mmcs_pkg::REQ_MAP, pick_sample(-32768, 65535),
                          1'($urandom_range(1)));
        end
    endtask

    // Mostly well-formed measure-then-map sequences, some loose noise items.
    task automatic run_traffic(input int n_items);
        int start;
        int base;
        int span;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            if ($urandom_range(99) < 85)
            begin
                pick_window(base, span);
                measure_pass(base, span, $urandom_range(1, 16));
                // under a fixed range, aim half the bursts at that range
                if (fixed_on && $urandom_range(1))
                begin
                    base = (fixed_lo < fixed_hi) ? int'(fixed_lo) : int'(fixed_hi);
                    span = (fixed_lo < fixed_hi) ? int'(fixed_hi) - int'(fixed_lo)
                                                 : int'(fixed_lo) - int'(fixed_hi);
                end
                map_burst(base, span, $urandom_range(1, 24));
            end
            else
                send_item(1'($urandom_range(1)), pick_sample(-32768, 65535),
                          1'($urandom_range(1)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic signed [15:0] m;
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = mmcs_pkg::CFG_FIXED_ENABLE;
        cfg_data  = '0;
        push      = 1'b0;
        req_type  = mmcs_pkg::REQ_MEASURE;
        sample    = '0;
        last      = 1'b0;
        fixed_on  = 1'b0;
        fixed_lo  = '0;
        fixed_hi  = 16'(mmcs_pkg::FIXED_MAX_RESET);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed, reset register values (measured range) ---
        // map before any finished pass: held range 0..0, flat
        send_item(mmcs_pkg::REQ_MAP, 16'sd0, 1'b0);
        // full-scale pass
        send_item(mmcs_pkg::REQ_MEASURE, -16'sd32768, 1'b0);
        send_item(mmcs_pkg::REQ_MEASURE, 16'sd32767, 1'b1);
        send_item(mmcs_pkg::REQ_MAP, -16'sd32768, 1'b0);
        send_item(mmcs_pkg::REQ_MAP, 16'sd32767, 1'b0);
        send_item(mmcs_pkg::REQ_MAP, 16'sd0, 1'b1);       // last on a map item is ignored
        send_item(mmcs_pkg::REQ_MAP, 16'sd1, 1'b0);
        send_item(mmcs_pkg::REQ_MAP, -16'sd1, 1'b0);
        // single-sample pass: flat report, flat maps
        send_item(mmcs_pkg::REQ_MEASURE, 16'sd5, 1'b1);
        send_item(mmcs_pkg::REQ_MAP, 16'sd5, 1'b0);
        send_item(mmcs_pkg::REQ_MAP, 16'sd4, 1'b0);
        // new minimum and new maximum both taken within one pass
        send_item(mmcs_pkg::REQ_MEASURE, 16'sd100, 1'b0);
        send_item(mmcs_pkg::REQ_MEASURE, 16'sd50, 1'b0);
        send_item(mmcs_pkg::REQ_MEASURE, 16'sd200, 1'b0);
        send_item(mmcs_pkg::REQ_MEASURE, 16'sd150, 1'b1);
        // below, at, inside, at and above the range
        send_item(mmcs_pkg::REQ_MAP, 16'sd49, 1'b0);
        send_item(mmcs_pkg::REQ_MAP, 16'sd50, 1'b0);
        send_item(mmcs_pkg::REQ_MAP, 16'sd51, 1'b0);
        send_item(mmcs_pkg::REQ_MAP, 16'sd199, 1'b0);
        send_item(mmcs_pkg::REQ_MAP, 16'sd200, 1'b0);
        send_item(mmcs_pkg::REQ_MAP, 16'sd250, 1'b0);
        settle();

        // fixed range at the extremes
        set_config(1'b1, -16'sd32768, 16'sd32767);
        send_item(mmcs_pkg::REQ_MAP, -16'sd32768, 1'b0);
        send_item(mmcs_pkg::REQ_MAP, 16'sd32767, 1'b0);
        send_item(mmcs_pkg::REQ_MAP, 16'sd0, 1'b0);
        settle();

        // inverted fixed range: flat
        set_config(1'b1, 16'sd100, -16'sd100);
        send_item(mmcs_pkg::REQ_MAP, 16'sd0, 1'b0);

        // --- random phases: idling pattern and register setting vary ---
        for (int p = 0; p < 12; p++)
        begin
            settle();
            case (p % 6)
                0: set_config(1'b0, pick_sample(-32768, 65535), pick_sample(-32768, 65535));
                1: set_config(1'b1, -16'sd32768, 16'sd32767);
                2: set_config(1'b1, 16'sd32767, -16'sd32768);
                3:
                begin
                    m = pick_sample(-32768, 65535);
                    set_config(1'b1, m, pick_sample(int'(m), $urandom_range(300)));
                end
                4: set_config(1'b1, pick_sample(-32768, 65535), pick_sample(-32768, 65535));
                default:
                begin
                    m = pick_sample(-32768, 65535);
                    set_config(1'b1, m, m);
                end
            endcase
            case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 50;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 50;
                end
                default:
                begin
                    send_idle_pct  = 23;
                    recv_stall_pct = 23;
                end
            endcase
            if (p == 5)
            begin
                // back-pressure: receiver blocked while a steady map burst
                // keeps coming, so the queue fills and full must hold off push
                send_idle_pct = 0;
                hold_phase    = 1'b1;
                map_burst(-100, 200, 40);
            end
            run_traffic(135);
        end
        settle();

        if (error_count == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: filelist.f
design/mmcs_pkg.sv
design/mmcs_queue.sv
design/mmcs_front.sv
design/mmcs_back.sv
design/min_max_contrast_stretch_unit.sv
bench/mmcs_stretch_checker.sv
bench/min_max_contrast_stretch_unit_tb.sv
